// File: src/k_way_merge_sorted_queue_macros.svh
// Assertion macros used by the merge queue datapath.
`ifndef K_WAY_MERGE_SORTED_QUEUE_MACROS_SVH
`define K_WAY_MERGE_SORTED_QUEUE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KWM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/kwm_pkg.sv
package kwm_pkg;

    localparam int WAYS   = 128;
    localparam int IDX_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNT_W  = $clog2(WAYS + 1);
    localparam int KEY_W  = 54;
    localparam int WAY_W  = 7;
    localparam int OCC_W  = 8;
    localparam int STAT_W = 2;
    localparam int ENT_W  = KEY_W + WAY_W;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STAT_W-1:0] ST_POPPED   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic srch_rd;
        logic srch_cmp;
        logic shf_rd;
        logic shf_wr;
        logic ins_wr;
        logic pop_rd;
        logic pop_out;
        logic res_full;
        logic res_empty;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic srch_done;
        logic shf_done;
        logic shf_last;
    } dp_stat_t;

endpackage

// File: src/kwm_ram.sv
module kwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/kwm_ctrl.sv
module kwm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               command,
    input  kwm_pkg::dp_stat_t  stat,
    output kwm_pkg::ctrl_cmd_t cmd,
    output logic               busy
);
    import kwm_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SRCH_RD  = 8'b0000_0010,
        S_SRCH_CMP = 8'b0000_0100,
        S_SHF_RD   = 8'b0000_1000,
        S_SHF_WR   = 8'b0001_0000,
        S_INS_WR   = 8'b0010_0000,
        S_POP_RD   = 8'b0100_0000,
        S_POP_OUT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch = 1'b1;
                    if (command == CMD_POP)
                    begin
                        if (stat.empty)
                        begin
                            cmd.res_empty = 1'b1;
                        end
                        else
                        begin
                            state_next = S_POP_RD;
                        end
                    end
                    else
                    begin
                        if (stat.full)
                        begin
                            cmd.res_full = 1'b1;
                        end
                        else
                        begin
                            state_next = S_SRCH_RD;
                        end
                    end
                end
            end
            S_SRCH_RD:
            begin
                if (stat.srch_done)
                begin
                    state_next = stat.shf_done ? S_INS_WR : S_SHF_RD;
                end
                else
                begin
                    cmd.srch_rd = 1'b1;
                    state_next  = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP:
            begin
                cmd.srch_cmp = 1'b1;
                state_next   = S_SRCH_RD;
            end
            S_SHF_RD:
            begin
                cmd.shf_rd = 1'b1;
                state_next = S_SHF_WR;
            end
            S_SHF_WR:
            begin
                cmd.shf_wr = 1'b1;
                state_next = stat.shf_last ? S_INS_WR : S_SHF_RD;
            end
            S_INS_WR:
            begin
                cmd.ins_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_POP_RD:
            begin
                cmd.pop_rd = 1'b1;
                state_next = S_POP_OUT;
            end
            S_POP_OUT:
            begin
                cmd.pop_out = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// File: src/kwm_dp.sv
`include "k_way_merge_sorted_queue_macros.svh"

module kwm_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  kwm_pkg::ctrl_cmd_t          cmd,
    output kwm_pkg::dp_stat_t           stat,
    input  logic [kwm_pkg::WAY_W-1:0]   way,
    input  logic [kwm_pkg::KEY_W-1:0]   key,
    output logic                        done,
    output logic [kwm_pkg::STAT_W-1:0]  status,
    output logic [kwm_pkg::WAY_W-1:0]   out_way,
    output logic [kwm_pkg::KEY_W-1:0]   out_key,
    output logic [kwm_pkg::OCC_W-1:0]   occupancy
);
    import kwm_pkg::*;

    // Entries live in a circular buffer: logical slot 0 is at head_reg.
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] h,
                                              input logic [CNT_W-1:0] l);
        logic [IDX_W:0] s;
        s = (IDX_W+1)'(h) + (IDX_W+1)'(l);
        if (s >= (IDX_W+1)'(WAYS))
        begin
            s = s - (IDX_W+1)'(WAYS);
        end
        return s[IDX_W-1:0];
    endfunction

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [CNT_W-1:0]  cur_reg, cur_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [WAY_W-1:0]  way_reg, way_next;
    logic              done_reg, done_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [WAY_W-1:0]  out_way_reg, out_way_next;
    logic [KEY_W-1:0]  out_key_reg, out_key_next;
    logic [OCC_W-1:0]  occupancy_reg, occupancy_next;

    logic [CNT_W:0]    mid_sum;
    logic [CNT_W-1:0]  mid;
    logic [CNT_W-1:0]  cur_m1;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [ENT_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [ENT_W-1:0]  ram_rdata;
    logic [KEY_W-1:0]  rd_key;
    logic [WAY_W-1:0]  rd_way;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CNT_W:1];
    assign cur_m1  = cur_reg - 1'b1;
    assign rd_key  = ram_rdata[KEY_W-1:0];
    assign rd_way  = ram_rdata[ENT_W-1:KEY_W];

    assign stat.full      = (count_reg == CNT_W'(WAYS));
    assign stat.empty     = (count_reg == '0);
    assign stat.srch_done = (lo_reg == hi_reg);
    assign stat.shf_done  = (cur_reg == lo_reg);
    assign stat.shf_last  = (cur_m1 == lo_reg);

    always_comb
    begin
        priority if (cmd.srch_rd)
        begin
            ram_raddr = phys(head_reg, mid);
        end
        else if (cmd.shf_rd)
        begin
            ram_raddr = phys(head_reg, cur_m1);
        end
        else
        begin
            ram_raddr = head_reg;
        end
    end

    assign ram_we    = cmd.shf_wr | cmd.ins_wr;
    assign ram_waddr = cmd.shf_wr ? phys(head_reg, cur_reg) : phys(head_reg, lo_reg);
    assign ram_wdata = cmd.shf_wr ? ram_rdata : {way_reg, key_reg};

    kwm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (WAYS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        cur_next       = cur_reg;
        key_next       = key_reg;
        way_next       = way_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        out_way_next   = out_way_reg;
        out_key_next   = out_key_reg;
        occupancy_next = occupancy_reg;

        if (cmd.latch)
        begin
            lo_next  = '0;
            hi_next  = count_reg;
            cur_next = count_reg;
            key_next = key;
            way_next = way;
        end

        // Lower-bound search: the first slot whose key is not below the new key.
        if (cmd.srch_cmp)
        begin
            if (rd_key >= key_reg)
            begin
                hi_next = mid;
            end
            else
            begin
                lo_next = mid + 1'b1;
            end
        end

        if (cmd.shf_wr)
        begin
            cur_next = cur_m1;
        end

        if (cmd.ins_wr)
        begin
            count_next     = count_reg + 1'b1;
            done_next      = 1'b1;
            status_next    = ST_INSERTED;
            out_way_next   = '0;
            out_key_next   = '0;
            occupancy_next = OCC_W'(count_next);
        end

        if (cmd.pop_out)
        begin
            count_next     = count_reg - 1'b1;
            head_next      = (head_reg == IDX_W'(WAYS - 1)) ? '0 : head_reg + 1'b1;
            done_next      = 1'b1;
            status_next    = ST_POPPED;
            out_way_next   = rd_way;
            out_key_next   = rd_key;
            occupancy_next = OCC_W'(count_next);
        end

        if (cmd.res_full || cmd.res_empty)
        begin
            done_next      = 1'b1;
            status_next    = cmd.res_full ? ST_FULL : ST_EMPTY;
            out_way_next   = '0;
            out_key_next   = '0;
            occupancy_next = OCC_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            cur_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            cur_reg   <= cur_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        way_reg       <= way_next;
        status_reg    <= status_next;
        out_way_reg   <= out_way_next;
        out_key_reg   <= out_key_next;
        occupancy_reg <= occupancy_next;
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign out_way   = out_way_reg;
    assign out_key   = out_key_reg;
    assign occupancy = occupancy_reg;

    `KWM_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(WAYS),
        "entry count above capacity")
    `KWM_ASSERT_IMPLY(a_search_order, clk, rst_n, cmd.srch_rd || cmd.srch_cmp,
        lo_reg <= hi_reg, "search bounds crossed")
    `KWM_ASSERT_IMPLY(a_shift_range, clk, rst_n, cmd.shf_rd, cur_reg > lo_reg,
        "shift below insert position")
    `KWM_ASSERT_NEXT(a_pop_count, clk, rst_n, cmd.pop_out,
        count_reg == CNT_W'($past(count_reg) - 1'b1), "pop did not lower the count")

endmodule

// File: src/k_way_merge_sorted_queue.sv
// Head queue of a k-way merge: keeps up to WAYS (way, key) entries sorted by key,
// with a new entry placed ahead of held entries of equal key. A request is taken
// when start is high and busy is low; every request yields exactly one result,
// shown for one cycle with done high, and the receiver cannot stall it. A rejected
// insert (full) or a pop on empty is answered from idle with no memory access; a
// pop reads the head entry; an insert runs a binary search for its slot, moves up
// each held entry whose key is equal or larger, and then writes the new entry. The
// run time is set by the single entry memory with registered read: the search costs
// one read per step and each moved entry one read and one write. The memory is
// used as a ring, so a pop moves nothing and no clearing pass follows reset.
module k_way_merge_sorted_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        command,
    input  logic [kwm_pkg::WAY_W-1:0]   way,
    input  logic [kwm_pkg::KEY_W-1:0]   key,
    output logic                        done,
    output logic [kwm_pkg::STAT_W-1:0]  status,
    output logic [kwm_pkg::WAY_W-1:0]   out_way,
    output logic [kwm_pkg::KEY_W-1:0]   out_key,
    output logic [kwm_pkg::OCC_W-1:0]   occupancy
);
    import kwm_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    kwm_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .cmd     (cmd),
        .busy    (busy)
    );

    kwm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .way       (way),
        .key       (key),
        .done      (done),
        .status    (status),
        .out_way   (out_way),
        .out_key   (out_key),
        .occupancy (occupancy)
    );

endmodule
